// ===== rtl/core/sbsh_pkg.sv =====
// Shared types, command codes and SHA-256 constants for the byte stream hasher.
package sbsh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  // byte source for a push into the block register
  localparam logic [1:0] SEL_IN   = 2'd0;
  localparam logic [1:0] SEL_PAD  = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  typedef struct packed {
    logic       push;      // shift one byte into the block
    logic [1:0] sel;       // byte source
    logic       count;     // add 8 to the bit length
    logic       start;     // load working vars from hash state
    logic       round;     // run one compression round
    logic [5:0] rnd;       // round number
    logic       final_add; // fold working vars into hash state
    logic       load_out;  // copy digest to output buffer, reinit hash
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_busy;
  } sts_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== rtl/core/sbsh_ctrl.sv =====
// Sequencer for absorb, padding, compression rounds and digest hand-off.
module sbsh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  sbsh_pkg::sts_t sts,
  output sbsh_pkg::cmd_t cmd
);
  import sbsh_pkg::*;

  localparam logic [2:0] S_ABSORB = 3'd0;
  localparam logic [2:0] S_PAD80  = 3'd1;
  localparam logic [2:0] S_PADZ   = 3'd2;
  localparam logic [2:0] S_PADLEN = 3'd3;
  localparam logic [2:0] S_ROUND  = 3'd4;
  localparam logic [2:0] S_FINAL  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] resume, resume_next;
  logic [5:0] rnd, rnd_next;
  logic       full;

  assign full = (sts.fill == 6'd63);

  always_comb begin
    cmd         = '0;
    cmd.rnd     = rnd;
    in_ready    = 1'b0;
    state_next  = state;
    resume_next = resume;
    rnd_next    = rnd;
    unique case (state)
      S_ABSORB: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push  = 1'b1;
          cmd.sel   = SEL_IN;
          cmd.count = 1'b1;
          if (full) begin
            cmd.start   = 1'b1;
            state_next  = S_ROUND;
            rnd_next    = 6'd0;
            resume_next = in_last ? S_PAD80 : S_ABSORB;
          end else if (in_last) begin
            state_next = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_PAD;
        if (full) begin
          cmd.start   = 1'b1;
          state_next  = S_ROUND;
          rnd_next    = 6'd0;
          resume_next = S_PADZ;
        end else begin
          state_next = S_PADZ;
        end
      end
      S_PADZ: begin
        if (sts.fill == 6'd56) begin
          state_next = S_PADLEN;
        end else begin
          cmd.push = 1'b1;
          cmd.sel  = SEL_ZERO;
          if (full) begin
            cmd.start   = 1'b1;
            state_next  = S_ROUND;
            rnd_next    = 6'd0;
            resume_next = S_PADZ;
          end
        end
      end
      S_PADLEN: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_LEN;
        if (full) begin
          cmd.start   = 1'b1;
          state_next  = S_ROUND;
          rnd_next    = 6'd0;
          resume_next = S_OUT;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + 6'd1;
        if (rnd == 6'd63) state_next = S_FINAL;
      end
      S_FINAL: begin
        cmd.final_add = 1'b1;
        state_next    = resume;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_ABSORB;
        end
      end
      default: begin
        state_next = S_ABSORB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_ABSORB;
      resume <= S_ABSORB;
      rnd    <= 6'd0;
    end else begin
      state  <= state_next;
      resume <= resume_next;
      rnd    <= rnd_next;
    end
  end

`ifndef ASSERT_OFF
  a_start_round: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == S_ROUND) && (rnd == 6'd0))
    else $error("block start did not enter round 0");

  a_last_round: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) && (rnd == 6'd63) |=> state == S_FINAL)
    else $error("round 63 not followed by final add");

  a_pad_len_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_PADLEN) |-> (sts.fill >= 6'd56))
    else $error("length bytes pushed below byte 56");
`endif

endmodule

// ===== rtl/core/sbsh_datapath.sv =====
// Block shift register, message schedule, round logic, hash state and output buffer.
module sbsh_datapath (
  input  logic           clk,
  input  logic           rst,
  input  sbsh_pkg::cmd_t cmd,
  input  logic [7:0]     in_byte,
  output sbsh_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_ready,
  output sbsh_pkg::out_t out_data
);
  import sbsh_pkg::*;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [511:0] blk;         // word i at [511-32i -: 32]; also the schedule window
  logic [5:0]   fill;
  logic [63:0]  msg_bits;
  logic [31:0]  hash [8];
  logic [31:0]  wk [8];      // a..h
  logic [255:0] obuf;
  logic [2:0]   out_cnt;

  logic [7:0]  push_byte;
  logic [31:0] w0, w1, w9, w14, w_new, sig0, sig1;
  logic [31:0] big_s0, big_s1, ch, maj, t1, t2;

  always_comb begin
    unique case (cmd.sel)
      SEL_IN:   push_byte = in_byte;
      SEL_PAD:  push_byte = 8'h80;
      SEL_ZERO: push_byte = 8'h00;
      SEL_LEN:  push_byte = msg_bits[{3'd7 - fill[2:0], 3'b000} +: 8];
    endcase
  end

  assign w0    = blk[511:480];
  assign w1    = blk[479:448];
  assign w9    = blk[223:192];
  assign w14   = blk[63:32];
  assign sig0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign sig1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = w0 + sig0 + w9 + sig1;

  assign big_s1 = rotr(wk[4], 6) ^ rotr(wk[4], 11) ^ rotr(wk[4], 25);
  assign ch     = (wk[4] & wk[5]) ^ (~wk[4] & wk[6]);
  assign t1     = wk[7] + big_s1 + ch + ROUND_K[cmd.rnd] + w0;
  assign big_s0 = rotr(wk[0], 2) ^ rotr(wk[0], 13) ^ rotr(wk[0], 22);
  assign maj    = (wk[0] & wk[1]) ^ (wk[0] & wk[2]) ^ (wk[1] & wk[2]);
  assign t2     = big_s0 + maj;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk <= {blk[503:0], push_byte};
    end else if (cmd.round) begin
      blk <= {blk[479:0], w_new};
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) wk[i] <= hash[i];
    end else if (cmd.round) begin
      wk[7] <= wk[6];
      wk[6] <= wk[5];
      wk[5] <= wk[4];
      wk[4] <= wk[3] + t1;
      wk[3] <= wk[2];
      wk[2] <= wk[1];
      wk[1] <= wk[0];
      wk[0] <= t1 + t2;
    end
    if (cmd.load_out) begin
      obuf <= {hash[0], hash[1], hash[2], hash[3], hash[4], hash[5], hash[6], hash[7]};
    end else if (out_valid && out_ready) begin
      obuf <= {obuf[223:0], 32'h0};
    end
  end

  // control and hash state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= 6'd0;
      msg_bits  <= 64'd0;
      out_valid <= 1'b0;
      out_cnt   <= 3'd0;
      for (int i = 0; i < 8; i++) hash[i] <= H_INIT[i];
    end else begin
      if (cmd.push) fill <= fill + 6'd1;
      if (cmd.count) msg_bits <= msg_bits + 64'd8;
      if (cmd.final_add) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + wk[i];
      end
      if (cmd.load_out) begin
        for (int i = 0; i < 8; i++) hash[i] <= H_INIT[i];
        msg_bits  <= 64'd0;
        fill      <= 6'd0;
        out_valid <= 1'b1;
        out_cnt   <= 3'd0;
      end else if (out_valid && out_ready) begin
        out_cnt <= out_cnt + 3'd1;
        if (out_cnt == 3'd7) out_valid <= 1'b0;
      end
    end
  end

  assign sts.fill     = fill;
  assign sts.out_busy = out_valid;

  assign out_data.digest_word = obuf[255:224];
  assign out_data.word_index  = out_cnt;
  assign out_data.last_word   = (out_cnt == 3'd7);

`ifndef ASSERT_OFF
  a_full_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.push && (fill == 6'd63) |-> cmd.start)
    else $error("full block not started");

  a_final_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.final_add |-> (fill == 6'd0) && !cmd.push)
    else $error("final add with partial block");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_valid)
    else $error("digest loaded over pending words");
`endif

endmodule

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher: controller plus datapath.
//
// Input channel (in_valid/in_ready/in_data): one message byte per transfer,
// last_byte set on the final byte of a message. Messages hold at least one byte.
// Output channel (out_valid/out_ready/out_data): eight transfers per message,
// digest words H0..H7 with word_index 0..7, last_word set on the eighth.
//
// Throughput: one byte transfer per cycle while a block fills. The 64th
// byte of a block starts 64 compression rounds (one per cycle, single round
// unit) and then a fold into the hash state, during which no byte is taken.
// After the last byte: the marker and zero bytes go in one per cycle, outside
// compression, up to byte 56, a state with no push, then eight length bytes
// (one more block when fewer than 9 bytes were free); each block is compressed
// and the digest buffer loads once no words are pending; then word 0 is valid.
// The digest sits in its own buffer, so a stalled receiver does not block
// the next message until its digest is ready while words are still pending.
// Reset (rst, synchronous) restores the initial hash values, clears the
// length and fill counts and drops any pending digest words.
module sha256_byte_stream_hasher (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sbsh_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sbsh_pkg::out_t out_data
);
  import sbsh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sbsh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_data.last_byte),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbsh_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_byte   (in_data.data_byte),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
